@@ rtl/gbce_pkg.sv @@
// Shared constants and pixel decoding functions for the glyph bitmap clip expander.
package gbce_pkg;

  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 320;

  localparam logic [2:0] REG_CLIP_LEFT    = 3'd0;
  localparam logic [2:0] REG_CLIP_TOP     = 3'd1;
  localparam logic [2:0] REG_CLIP_RIGHT   = 3'd2;
  localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd3;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd4;

  localparam logic [3:0] BPP_1 = 4'd1;
  localparam logic [3:0] BPP_2 = 4'd2;
  localparam logic [3:0] BPP_4 = 4'd4;
  localparam logic [3:0] BPP_8 = 4'd8;

  localparam logic [7:0] COV_FULL = 8'hFF;

  function automatic logic [3:0] gbce_per_byte(input logic [3:0] bpp);
    logic [3:0] n;
    unique case (bpp)
      BPP_1:   n = 4'd8;
      BPP_2:   n = 4'd4;
      BPP_4:   n = 4'd2;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // Takes the leading pixel of a left-aligned byte and maps it to coverage.
  function automatic logic [7:0] gbce_coverage(input logic [7:0] bits, input logic [3:0] bpp);
    logic [7:0] cov;
    unique case (bpp)
      BPP_1: cov = bits[7] ? COV_FULL : 8'd0;
      BPP_2: begin
        unique case (bits[7:6])
          2'd0:    cov = 8'd0;
          2'd1:    cov = 8'd85;
          2'd2:    cov = 8'd170;
          default: cov = COV_FULL;
        endcase
      end
      BPP_4:   cov = {bits[7:4], bits[7:4]};
      default: cov = bits;
    endcase
    return cov;
  endfunction

  function automatic logic [7:0] gbce_shift(input logic [7:0] bits, input logic [3:0] bpp);
    logic [7:0] s;
    unique case (bpp)
      BPP_1:   s = {bits[6:0], 1'b0};
      BPP_2:   s = {bits[5:0], 2'b0};
      BPP_4:   s = {bits[3:0], 4'b0};
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/glyph_bitmap_clip_expander.sv @@
// Top level of the glyph bitmap clip expander: glyph sequencer, clip test and result register.
// After a start transfer the block is ready again in the next cycle.
// A bitmap byte holds the input stalled while it passes the row, pixel and flush states, one
// pixel slot at a time through the shared clip test for the pixels it carries within the glyph
// width, plus any output stall. Each visible pixel waits in a pending register and moves to the
// result register when the next visible pixel comes or at flush; at most one result per cycle.
// Synchronous active-low reset restores the clip rectangle to the screen, the height to
// sixteen rows and leaves no glyph active; nothing needs clearing afterwards.
module glyph_bitmap_clip_expander
  import gbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_origin_x,
  input  logic [15:0] in_origin_y,
  input  logic [7:0]  in_glyph_width,
  input  logic [3:0]  in_bits_per_pixel,
  input  logic [7:0]  in_bitmap_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pixel_x,
  output logic [11:0] out_pixel_y,
  output logic [7:0]  out_coverage,
  output logic        out_last_in_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_PIX, S_FLUSH} state_t;

  state_t      state_r;
  logic [15:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [7:0]  glyph_height_r;
  logic [15:0] glyph_left_r, glyph_top_r;
  logic [7:0]  width_pixels_r;
  logic [3:0]  bit_depth_r;
  logic        glyph_active_r;
  logic [7:0]  row_index_r, column_index_r;
  logic [7:0]  shift_r;
  logic [3:0]  cnt_r;
  logic [11:0] y_r;
  logic        y_ok_r;
  logic        pend_v_r;
  logic [11:0] pend_x_r;
  logic [7:0]  pend_cov_r;
  logic        out_valid_r;
  logic [11:0] out_x_r, out_y_r;
  logic [7:0]  out_cov_r;
  logic        out_last_r;

  logic signed [16:0] cl, ct, cr, cb, x_w, y_w;
  logic [7:0]  cov_w;
  logic        vis_w, y_ok_w, out_free, pix_done, advance, out_load;

  assign cl  = {clip_left_r[15], clip_left_r};
  assign ct  = {clip_top_r[15], clip_top_r};
  assign cr  = {clip_right_r[15], clip_right_r};
  assign cb  = {clip_bottom_r[15], clip_bottom_r};
  assign x_w = {glyph_left_r[15], glyph_left_r} + {9'd0, column_index_r};
  assign y_w = {glyph_top_r[15], glyph_top_r} + {9'd0, row_index_r};

  assign y_ok_w = (y_w >= ct) && (y_w <= cb) && (y_w >= 17'sd0) &&
                  (y_w < $signed(17'(SCREEN_HEIGHT)));
  assign cov_w  = gbce_coverage(shift_r, bit_depth_r);
  assign vis_w  = (cov_w != 8'd0) && y_ok_r && (x_w >= cl) && (x_w <= cr) &&
                  (x_w >= 17'sd0) && (x_w < $signed(17'(SCREEN_WIDTH)));

  assign out_free = !out_valid_r || !out_stall;
  assign pix_done = (column_index_r >= width_pixels_r) || (cnt_r == 4'd0);
  assign advance  = !(vis_w && pend_v_r && !out_free);
  assign out_load = ((state_r == S_PIX) && !pix_done && advance && vis_w && pend_v_r) ||
                    ((state_r == S_FLUSH) && pend_v_r && out_free);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_coverage    = out_cov_r;
  assign out_last_in_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      clip_left_r    <= 16'd0;
      clip_top_r     <= 16'd0;
      clip_right_r   <= 16'd479;
      clip_bottom_r  <= 16'd319;
      glyph_height_r <= 8'd16;
      glyph_left_r   <= 16'd0;
      glyph_top_r    <= 16'd0;
      width_pixels_r <= 8'd0;
      bit_depth_r    <= 4'd0;
      glyph_active_r <= 1'b0;
      row_index_r    <= 8'd0;
      column_index_r <= 8'd0;
      pend_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLIP_LEFT:    clip_left_r    <= cfg_data;
          REG_CLIP_TOP:     clip_top_r     <= cfg_data;
          REG_CLIP_RIGHT:   clip_right_r   <= cfg_data;
          REG_CLIP_BOTTOM:  clip_bottom_r  <= cfg_data;
          REG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_req_type) begin
              glyph_left_r   <= in_origin_x;
              glyph_top_r    <= in_origin_y;
              width_pixels_r <= in_glyph_width;
              bit_depth_r    <= in_bits_per_pixel;
              glyph_active_r <= (in_bits_per_pixel == BPP_1) || (in_bits_per_pixel == BPP_2) ||
                                (in_bits_per_pixel == BPP_4) || (in_bits_per_pixel == BPP_8);
              row_index_r    <= 8'd0;
              column_index_r <= 8'd0;
            end else if (glyph_active_r && (width_pixels_r != 8'd0) &&
                         (row_index_r < glyph_height_r)) begin
              shift_r <= in_bitmap_byte;
              cnt_r   <= gbce_per_byte(bit_depth_r);
              state_r <= S_ROW;
            end
          end
        end
        S_ROW: begin
          y_r      <= y_w[11:0];
          y_ok_r   <= y_ok_w;
          pend_v_r <= 1'b0;
          state_r  <= S_PIX;
        end
        S_PIX: begin
          if (pix_done) begin
            state_r <= S_FLUSH;
          end else if (advance) begin
            column_index_r <= column_index_r + 8'd1;
            cnt_r          <= cnt_r - 4'd1;
            shift_r        <= gbce_shift(shift_r, bit_depth_r);
            if (vis_w) begin
              pend_v_r   <= 1'b1;
              pend_x_r   <= x_w[11:0];
              pend_cov_r <= cov_w;
              if (pend_v_r) begin
                out_x_r    <= pend_x_r;
                out_y_r    <= y_r;
                out_cov_r  <= pend_cov_r;
                out_last_r <= 1'b0;
              end
            end
          end
        end
        S_FLUSH: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_x_r    <= pend_x_r;
              out_y_r    <= y_r;
              out_cov_r  <= pend_cov_r;
              out_last_r <= 1'b1;
            end
            pend_v_r <= 1'b0;
            if (column_index_r >= width_pixels_r) begin
              column_index_r <= 8'd0;
              row_index_r    <= row_index_r + 8'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/gbce_checker.sv @@
// Port-level checker for the glyph bitmap clip expander and its bind statement.
module gbce_checker
  import gbce_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_pixel_x,
  input logic [11:0] out_pixel_y,
  input logic [7:0]  out_coverage,
  input logic        out_last_in_run
);

  // A stalled result must hold until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) &&
    $stable(out_coverage) && $stable(out_last_in_run))
    else $error("stalled result changed");

  a_cov_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coverage != 8'd0)
    else $error("result with zero coverage");

  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_pixel_x) < SCREEN_WIDTH) && (32'(out_pixel_y) < SCREEN_HEIGHT))
    else $error("result outside the screen");

  // A glyph start leaves the block ready to take the next transfer.
  a_start_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_req_type |=> !in_stall)
    else $error("block busy after a glyph start");

endmodule

bind glyph_bitmap_clip_expander gbce_checker u_gbce_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_coverage    (out_coverage),
  .out_last_in_run (out_last_in_run)
);

@@ dv/gbce_pixel_checker.sv @@
// Checker for the glyph bitmap clip expander: predicts the pixel stream and compares it.
`timescale 1ns / 100ps
module gbce_pixel_checker
  import gbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_origin_x,
  input  logic [15:0] in_origin_y,
  input  logic [7:0]  in_glyph_width,
  input  logic [3:0]  in_bits_per_pixel,
  input  logic [7:0]  in_bitmap_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_pixel_x,
  input  logic [11:0] out_pixel_y,
  input  logic [7:0]  out_coverage,
  input  logic        out_last_in_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  cov;
    logic        last;
  } pixel_t;

  pixel_t             expected_pixels [$];
  pixel_t             run_buf [8];
  pixel_t             want;
  logic signed [15:0] clip_l, clip_t, clip_r, clip_b;
  logic [7:0]         rows_per_glyph;
  logic signed [15:0] org_x, org_y;
  logic [7:0]         width_px, row_pos, col_pos;
  logic [3:0]         depth;
  logic               active;
  int                 per, bpp_i, mask, step, raw, px, py, k, n;
  int                 fails = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      clip_l = 16'sd0;
      clip_t = 16'sd0;
      clip_r = 16'sd479;
      clip_b = 16'sd319;
      rows_per_glyph = 8'd16;
      org_x = 16'sd0;
      org_y = 16'sd0;
      width_px = 8'd0;
      depth = 4'd0;
      active = 1'b0;
      row_pos = 8'd0;
      col_pos = 8'd0;
      expected_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          fails++;
          $display("%0t: expected no pixel, got x=%0d y=%0d coverage=%0d last=%0b", $time,
                   out_pixel_x, out_pixel_y, out_coverage, out_last_in_run);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_x !== want.x || out_pixel_y !== want.y ||
              out_coverage !== want.cov || out_last_in_run !== want.last) begin
            fails++;
            $display("%0t: expected (%0d,%0d) cov %0d last %0b, got (%0d,%0d) cov %0d last %0b",
                     $time, want.x, want.y, want.cov, want.last,
                     out_pixel_x, out_pixel_y, out_coverage, out_last_in_run);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_CLIP_LEFT:    clip_l = cfg_data;
          REG_CLIP_TOP:     clip_t = cfg_data;
          REG_CLIP_RIGHT:   clip_r = cfg_data;
          REG_CLIP_BOTTOM:  clip_b = cfg_data;
          REG_GLYPH_HEIGHT: rows_per_glyph = cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (!in_req_type) begin
          org_x = in_origin_x;
          org_y = in_origin_y;
          width_px = in_glyph_width;
          depth = in_bits_per_pixel;
          active = (depth == BPP_1) || (depth == BPP_2) || (depth == BPP_4) || (depth == BPP_8);
          row_pos = 8'd0;
          col_pos = 8'd0;
        end else if (active && width_px != 8'd0 && row_pos < rows_per_glyph) begin
          bpp_i = int'(depth);
          per = 8 / bpp_i;
          mask = (1 << bpp_i) - 1;
          step = 255 / mask;
          py = int'(org_y) + int'(row_pos);
          n = 0;
          for (k = 0; k < per && col_pos < width_px; k++) begin
            raw = (int'(in_bitmap_byte) >> (8 - bpp_i * (k + 1))) & mask;
            px = int'(org_x) + int'(col_pos);
            col_pos++;
            if (raw != 0 && px >= clip_l && px <= clip_r && py >= clip_t && py <= clip_b &&
                px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT) begin
              run_buf[n].x = px[11:0];
              run_buf[n].y = py[11:0];
              run_buf[n].cov = 8'(raw * step);
              run_buf[n].last = 1'b0;
              n++;
            end
          end
          if (col_pos >= width_px) begin
            col_pos = 8'd0;
            row_pos++;
          end
          for (k = 0; k < n; k++) begin
            run_buf[k].last = (k == n - 1);
            expected_pixels.push_back(run_buf[k]);
          end
        end
      end
    end
    errors <= fails;
    outstanding <= expected_pixels.size();
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the glyph bitmap clip expander: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top
  import gbce_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [15:0] in_origin_x;
  logic [15:0] in_origin_y;
  logic [7:0]  in_glyph_width;
  logic [3:0]  in_bits_per_pixel;
  logic [7:0]  in_bitmap_byte;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_pixel_x;
  logic [11:0] out_pixel_y;
  logic [7:0]  out_coverage;
  logic        out_last_in_run;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          outstanding;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;
  int          glyph_rows;
  int          win_l, win_t, win_r, win_b;

  glyph_bitmap_clip_expander u_dut (.*);

  gbce_pixel_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // The receiver either stalls at random or, once asked, holds off for a long stretch.
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic offer(input logic req, input logic [15:0] ox, input logic [15:0] oy,
                       input logic [7:0] w, input logic [3:0] bpp, input logic [7:0] bits);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_glyph_width <= w;
    in_bits_per_pixel <= bpp;
    in_bitmap_byte <= bits;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic start_glyph(input logic [15:0] ox, input logic [15:0] oy,
                             input logic [7:0] w, input logic [3:0] bpp);
    offer(1'b0, ox, oy, w, bpp, 8'($urandom));
  endtask

  task automatic push_byte(input logic [7:0] bits);
    offer(1'b1, 16'($urandom), 16'($urandom), 8'($urandom), 4'($urandom), bits);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic program_clip(input int l, input int t, input int r, input int b, input int h);
    write_reg(REG_CLIP_LEFT, l[15:0]);
    write_reg(REG_CLIP_TOP, t[15:0]);
    write_reg(REG_CLIP_RIGHT, r[15:0]);
    write_reg(REG_CLIP_BOTTOM, b[15:0]);
    write_reg(REG_GLYPH_HEIGHT, {8'd0, h[7:0]});
    cfg_we <= 1'b0;
    win_l = l;
    win_t = t;
    win_r = r;
    win_b = b;
    glyph_rows = h;
  endtask

  task automatic run_random(input int items);
    int          sent, sel, count, row_bytes, lo_x, hi_x, lo_y, hi_y;
    logic [15:0] ox, oy;
    logic [7:0]  w;
    logic [3:0]  bpp;
    sent = 0;
    lo_x = (win_l > 0) ? win_l : 0;
    hi_x = (win_r < SCREEN_WIDTH - 1) ? win_r : SCREEN_WIDTH - 1;
    lo_y = (win_t > 0) ? win_t : 0;
    hi_y = (win_b < SCREEN_HEIGHT - 1) ? win_b : SCREEN_HEIGHT - 1;
    if (hi_x < lo_x) begin
      lo_x = 0;
      hi_x = SCREEN_WIDTH - 1;
    end
    if (hi_y < lo_y) begin
      lo_y = 0;
      hi_y = SCREEN_HEIGHT - 1;
    end
    while (sent < items) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        offer(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom), 8'($urandom));
        sent++;
      end else begin
        ox = (sel == 1) ? 16'($urandom) : 16'(lo_x - 20 + $urandom_range(0, hi_x - lo_x + 40));
        oy = (sel == 2) ? 16'($urandom) : 16'(lo_y - 20 + $urandom_range(0, hi_y - lo_y + 40));
        bpp = (sel == 3) ? 4'($urandom_range(0, 15)) : 4'(4'd1 << $urandom_range(0, 3));
        w = (sel == 4) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 20));
        row_bytes = (int'(w) * int'(bpp) + 7) / 8;
        if (row_bytes < 1) row_bytes = 1;
        count = row_bytes * glyph_rows + $urandom_range(0, 2);
        if (count > 36) count = $urandom_range(8, 36);
        start_glyph(ox, oy, w, bpp);
        sent++;
        while (count > 0 && sent < items) begin
          push_byte(8'($urandom));
          count--;
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= 1'b0;
    in_origin_x <= 16'd0;
    in_origin_y <= 16'd0;
    in_glyph_width <= 8'd0;
    in_bits_per_pixel <= 4'd0;
    in_bitmap_byte <= 8'd0;
    cfg_we <= 1'b0;
    cfg_index <= REG_CLIP_LEFT;
    cfg_data <= 16'd0;
    hold_req <= 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 73;
    glyph_rows = 16;
    win_l = 0;
    win_t = 0;
    win_r = SCREEN_WIDTH - 1;
    win_b = SCREEN_HEIGHT - 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A byte with no glyph started must be ignored.
    push_byte(8'hFF);
    start_glyph(16'd0, 16'd0, 8'd8, BPP_1);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h00);
    push_byte(8'h01);
    // Two-bit pixels running off the right of the screen.
    start_glyph(16'd476, 16'd318, 8'd8, BPP_2);
    push_byte(8'h1B);
    push_byte(8'hE4);
    push_byte(8'hFF);
    // A narrow glyph straddling the top-left corner, with row padding discarded.
    start_glyph(16'hFFFF, 16'hFFFF, 8'd3, BPP_4);
    push_byte(8'hF1);
    push_byte(8'h8F);
    push_byte(8'h7E);
    push_byte(8'h10);
    start_glyph(16'd100, 16'd200, 8'd2, BPP_8);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    start_glyph(16'd10, 16'd10, 8'd8, 4'd3);
    push_byte(8'hFF);
    start_glyph(16'd10, 16'd10, 8'd0, BPP_1);
    push_byte(8'hFF);
    start_glyph(16'h7FFF, 16'h8000, 8'hFF, BPP_1);
    push_byte(8'hFF);
    run_random(80);
    settle();

    program_clip(-32768, -32768, 32767, 32767, 255);
    run_random(90);
    settle();

    send_idle_pct = 73;
    recv_idle_pct = 33;
    program_clip(300, 100, 340, 140, 3);
    run_random(90);
    settle();

    // An inverted rectangle and zero height leave nothing visible.
    program_clip(200, 50, 100, 250, 0);
    run_random(40);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    win_l = $urandom_range(0, 300) - 20;
    win_t = $urandom_range(0, 200) - 20;
    program_clip(win_l, win_t, win_l + $urandom_range(20, 300), win_t + $urandom_range(20, 200),
                 $urandom_range(1, 12));
    hold_req <= 1'b1;
    run_random(130);
    settle();

    if (errors == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ glyph_bitmap_clip_expander.f @@
rtl/gbce_pkg.sv
rtl/glyph_bitmap_clip_expander.sv
rtl/gbce_checker.sv
dv/gbce_pixel_checker.sv
dv/tb_top.sv
